>>> hw/rtl/dtq_pkg.sv
`timescale 1ns / 1ps

package dtq_pkg;

    // Request codes
    localparam logic CMD_SCHEDULE = 1'b0;
    localparam logic CMD_UPDATE   = 1'b1;

    // Response status codes
    localparam logic [1:0] ST_SCHEDULED = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_FIRED     = 2'd2;
    localparam logic [1:0] ST_NONE      = 2'd3;

    typedef struct packed {
        logic        command;
        logic [31:0] now_time;
        logic [31:0] delay_ticks;
        logic [7:0]  token;
    } t_in_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  fired_token;
        logic [31:0] fired_deadline;
        logic        last;
    } t_out_rsp;

    // Controller to datapath
    typedef struct packed {
        logic       load_in;
        logic       insert;
        logic       pop;
        logic       out_load;
        logic [1:0] out_status;
        logic       out_last;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic head_due;
        logic next_due;
        logic full;
        logic out_free;
    } t_dp_sts;

endpackage

>>> hw/rtl/dtq_ctrl.sv
`timescale 1ns / 1ps

module dtq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_command,
    input  dtq_pkg::t_dp_sts i_sts,
    output logic             o_in_ready,
    output dtq_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCHED = 3'b010,
        S_UPD   = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd.load_in    = 1'b0;
        o_cmd.insert     = 1'b0;
        o_cmd.pop        = 1'b0;
        o_cmd.out_load   = 1'b0;
        o_cmd.out_status = dtq_pkg::ST_NONE;
        o_cmd.out_last   = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = (i_in_command == dtq_pkg::CMD_UPDATE) ? S_UPD : S_SCHED;
                end
            end
            S_SCHED: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.insert     = !i_sts.full;
                    o_cmd.out_status = i_sts.full ? dtq_pkg::ST_FULL
                                                  : dtq_pkg::ST_SCHEDULED;
                    n_state = S_IDLE;
                end
            end
            S_UPD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.head_due) begin
                        // Release the head; stop once the next one is not due
                        o_cmd.pop        = 1'b1;
                        o_cmd.out_status = dtq_pkg::ST_FIRED;
                        o_cmd.out_last   = !i_sts.next_due;
                        if (!i_sts.next_due) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/dtq_dp.sv
`timescale 1ns / 1ps

module dtq_dp #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TOKEN_BITS  = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dtq_pkg::t_in_req  i_in_req,
    input  dtq_pkg::t_dp_cmd  i_cmd,
    input  logic              i_out_ready,
    output dtq_pkg::t_dp_sts  o_sts,
    output logic              o_out_valid,
    output dtq_pkg::t_out_rsp o_out_rsp
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [31:0]           r_dl  [QUEUE_DEPTH];
    logic [TOKEN_BITS-1:0] r_tok [QUEUE_DEPTH];
    logic [CW-1:0]         r_count;
    logic [31:0]           r_new_dl;
    logic [TOKEN_BITS-1:0] r_new_tok;
    logic [31:0]           r_now;
    logic                  r_out_valid;
    dtq_pkg::t_out_rsp     r_out_rsp;

    logic [32:0]            w_sum;
    logic [TOKEN_BITS+7:0]  w_tok_in_ext;
    logic [TOKEN_BITS+7:0]  w_tok_out_ext;
    logic [QUEUE_DEPTH-1:0] w_gt;

    // Saturating deadline
    assign w_sum        = {1'b0, i_in_req.now_time} + {1'b0, i_in_req.delay_ticks};
    assign w_tok_in_ext = {{TOKEN_BITS{1'b0}}, i_in_req.token};
    assign w_tok_out_ext = {8'b0, r_tok[0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_new_dl  <= w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
            r_new_tok <= w_tok_in_ext[TOKEN_BITS-1:0];
            r_now     <= i_in_req.now_time;
        end
    end

    // Sorted register row: entry 0 holds the earliest deadline
    genvar g;
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_ent
        logic                  w_wr;
        logic                  w_take_prev;
        logic [31:0]           w_prev_dl;
        logic [TOKEN_BITS-1:0] w_prev_tok;
        logic [31:0]           w_next_dl;
        logic [TOKEN_BITS-1:0] w_next_tok;

        assign w_gt[g] = (CW'(g) < r_count) && (r_dl[g] > r_new_dl);
        assign w_wr    = w_gt[g] || (CW'(g) == r_count);

        if (g == 0) begin : g_first
            assign w_take_prev = 1'b0;
            assign w_prev_dl   = r_new_dl;
            assign w_prev_tok  = r_new_tok;
        end else begin : g_rest
            assign w_take_prev = w_gt[g-1];
            assign w_prev_dl   = r_dl[g-1];
            assign w_prev_tok  = r_tok[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_next_dl  = r_dl[g];
            assign w_next_tok = r_tok[g];
        end else begin : g_body
            assign w_next_dl  = r_dl[g+1];
            assign w_next_tok = r_tok[g+1];
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.insert && w_wr) begin
                r_dl[g]  <= w_take_prev ? w_prev_dl : r_new_dl;
                r_tok[g] <= w_take_prev ? w_prev_tok : r_new_tok;
            end else if (i_cmd.pop) begin
                r_dl[g]  <= w_next_dl;
                r_tok[g] <= w_next_tok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.insert) begin
            r_count <= r_count + 1'b1;
        end else if (i_cmd.pop) begin
            r_count <= r_count - 1'b1;
        end
    end

    assign o_sts.head_due = (r_count != '0) && (r_dl[0] <= r_now);
    assign o_sts.next_due = (r_count > CW'(1)) && (r_dl[1] <= r_now);
    assign o_sts.full     = (r_count == CW'(QUEUE_DEPTH));
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_rsp.status <= i_cmd.out_status;
            r_out_rsp.last   <= i_cmd.out_last;
            if (i_cmd.out_status == dtq_pkg::ST_FIRED) begin
                r_out_rsp.fired_token    <= w_tok_out_ext[7:0];
                r_out_rsp.fired_deadline <= r_dl[0];
            end else begin
                r_out_rsp.fired_token    <= 8'd0;
                r_out_rsp.fired_deadline <= 32'd0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

>>> hw/rtl/deadline_timer_queue.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake                  | Payload
// in      | input     | i_in_valid / o_in_ready    | i_in_req  (dtq_pkg::t_in_req)
// out     | output    | o_out_valid / i_out_ready  | o_out_rsp (dtq_pkg::t_out_rsp)
//
// Schedule: latch the saturated deadline on accept, then insert it into the
//   sorted register row as the response loads, once the output is free.
// Update: latch the time, then pop one token per cycle from the head of the row
//   while the output register is free; an empty release returns ST_NONE.
// One request at a time; o_in_ready is high only while the controller idles.
// Reset empties the queue at once (fill count cleared); no sweep needed.
// A stalled response holds in the output register and freezes the release.

module deadline_timer_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TOKEN_BITS  = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dtq_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dtq_pkg::t_out_rsp o_out_rsp
);

    // Command and status between controller and datapath
    dtq_pkg::t_dp_cmd w_cmd;
    dtq_pkg::t_dp_sts w_sts;

    // Sequence schedule/update requests and drive the datapath
    dtq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_command(i_in_req.command),
        .i_sts       (w_sts),
        .o_in_ready  (o_in_ready),
        .o_cmd       (w_cmd)
    );

    // Hold the sorted queue, the request latch and the response register
    dtq_dp #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .TOKEN_BITS (TOKEN_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_req   (i_in_req),
        .i_cmd      (w_cmd),
        .i_out_ready(i_out_ready),
        .o_sts      (w_sts),
        .o_out_valid(o_out_valid),
        .o_out_rsp  (o_out_rsp)
    );

`ifndef SYNTH
    // Never overwrite a response that has not been taken
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("response loaded while output register busy");

    // Release only a due head entry
    a_pop_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.pop |-> w_sts.head_due)
        else $error("pop without a due entry");

    // Never insert into a full queue
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.insert |-> !w_sts.full)
        else $error("insert into full queue");

    // A request in progress blocks the next one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready stayed high after accept");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int QUEUE_DEPTH = 16;
    localparam int TOKEN_BITS  = 8;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    dtq_pkg::t_in_req  in_req      = '0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    dtq_pkg::t_out_rsp out_rsp;

    // Shadow copy of the sorted queue, held as two parallel lists
    logic [31:0]       pending_deadline[$];
    logic [7:0]        pending_token[$];
    // Responses still owed by the block, oldest first
    dtq_pkg::t_out_rsp expected_rsp_q[$];

    int failures    = 0;
    int n_requests  = 0;
    int n_scheduled = 0;
    int n_dropped   = 0;
    int n_released  = 0;
    int n_idle_upd  = 0;

    // Sender burst state
    int  burst_left = 1;
    bit  tx_active  = 1'b0;

    // Receiver stall state: a rotating ready mask, plus a long hold-off on request
    logic [7:0] rx_mask       = 8'hFF;
    logic [2:0] rx_phase      = '0;
    int         rx_mask_age   = 0;
    int         rx_hold_req   = 0;
    int         rx_hold_left  = 0;

    logic [31:0] sim_tick = '0;

    deadline_timer_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TOKEN_BITS  (TOKEN_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_rsp   (out_rsp)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog: far beyond the slowest legal run
    initial begin
        #500_000;
        $display("simulation failed");
        $finish;
    end

    function automatic dtq_pkg::t_in_req make_schedule(input logic [31:0] now,
                                                       input logic [31:0] delay,
                                                       input logic [7:0]  tok);
        dtq_pkg::t_in_req req;
        req             = '0;
        req.command     = dtq_pkg::CMD_SCHEDULE;
        req.now_time    = now;
        req.delay_ticks = delay;
        req.token       = tok;
        return req;
    endfunction

    function automatic dtq_pkg::t_in_req make_update(input logic [31:0] now);
        dtq_pkg::t_in_req req;
        req          = '0;
        req.command  = dtq_pkg::CMD_UPDATE;
        req.now_time = now;
        return req;
    endfunction

    // Work out the responses one accepted request causes and update the shadow queue.
    function automatic void predict_timer_queue(input dtq_pkg::t_in_req req);
        dtq_pkg::t_out_rsp rsp;
        logic [32:0]       sum;
        logic [31:0]       deadline;
        int                pos;
        int                due;
        int                k;
        rsp = '0;
        if (req.command == dtq_pkg::CMD_SCHEDULE) begin
            // Saturate the deadline at the top of the range on carry out
            sum      = {1'b0, req.now_time} + {1'b0, req.delay_ticks};
            deadline = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            rsp.last = 1'b1;
            if (pending_deadline.size() >= QUEUE_DEPTH) begin
                rsp.status = dtq_pkg::ST_FULL;
                n_dropped++;
            end else begin
                // Place after every entry with an equal or earlier deadline
                pos = pending_deadline.size();
                while (pos > 0 && pending_deadline[pos-1] > deadline)
                    pos--;
                pending_deadline.insert(pos, deadline);
                pending_token.insert(pos, req.token);
                rsp.status = dtq_pkg::ST_SCHEDULED;
                n_scheduled++;
            end
            expected_rsp_q.push_back(rsp);
        end else begin
            due = 0;
            while (due < pending_deadline.size() && pending_deadline[due] <= req.now_time)
                due++;
            if (due == 0) begin
                rsp.status = dtq_pkg::ST_NONE;
                rsp.last   = 1'b1;
                expected_rsp_q.push_back(rsp);
                n_idle_upd++;
            end else begin
                for (k = 0; k < due; k++) begin
                    rsp.status         = dtq_pkg::ST_FIRED;
                    rsp.fired_token    = pending_token.pop_front();
                    rsp.fired_deadline = pending_deadline.pop_front();
                    rsp.last           = (k == due - 1);
                    expected_rsp_q.push_back(rsp);
                end
                n_released += due;
            end
        end
    endfunction

    // Offer one request, hold it until accepted, then predict it.
    // Lower valid only when the current burst runs out.
    task automatic send_request(input dtq_pkg::t_in_req req);
        int gap;
        in_req    <= req;
        in_valid  <= 1'b1;
        tx_active = 1'b1;
        do
            @(posedge i_clk);
        while (!in_ready);
        predict_timer_queue(req);
        n_requests++;
        burst_left--;
        if (burst_left <= 0) begin
            in_valid  <= 1'b0;
            tx_active = 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 8);
        end
    endtask

    // Drop valid if still offering, then wait until every owed response is back.
    task automatic drain_responses();
        if (tx_active) begin
            in_valid  <= 1'b0;
            tx_active = 1'b0;
        end
        while (expected_rsp_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Receiver: hold off on request, otherwise follow the rotating mask
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (rx_hold_req > 0 || rx_hold_left > 0) begin
            if (rx_hold_req > 0) begin
                rx_hold_left = rx_hold_req;
                rx_hold_req  = 0;
            end
            out_ready <= 1'b0;
            rx_hold_left--;
        end else begin
            out_ready <= rx_mask[rx_phase];
            rx_phase  <= rx_phase + 3'd1;
            rx_mask_age++;
            if (rx_mask_age >= 64) begin
                rx_mask_age = 0;
                case ($urandom_range(0, 3))
                    0, 1: begin
                        rx_mask <= 8'hFF;
                    end
                    default: begin
                        rx_mask <= 8'($urandom) | 8'h01;
                    end
                endcase
            end
        end
    end

    // Compare every accepted response with the oldest owed one
    always @(posedge i_clk) begin
        dtq_pkg::t_out_rsp exp_rsp;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_rsp_q.size() == 0) begin
                $error("unexpected response: status %0d token %0h deadline %0h last %0d",
                       out_rsp.status, out_rsp.fired_token, out_rsp.fired_deadline,
                       out_rsp.last);
                failures++;
            end else begin
                exp_rsp = expected_rsp_q.pop_front();
                if (out_rsp.status !== exp_rsp.status) begin
                    $error("status: expected %0d, got %0d", exp_rsp.status, out_rsp.status);
                    failures++;
                end
                if (out_rsp.fired_token !== exp_rsp.fired_token) begin
                    $error("fired_token: expected %0h, got %0h",
                           exp_rsp.fired_token, out_rsp.fired_token);
                    failures++;
                end
                if (out_rsp.fired_deadline !== exp_rsp.fired_deadline) begin
                    $error("fired_deadline: expected %0h, got %0h",
                           exp_rsp.fired_deadline, out_rsp.fired_deadline);
                    failures++;
                end
                if (out_rsp.last !== exp_rsp.last) begin
                    $error("last: expected %0d, got %0d", exp_rsp.last, out_rsp.last);
                    failures++;
                end
            end
        end
    end

    // Update on an empty queue must report nothing due
    task automatic test_empty_update();
        send_request(make_update(32'd0));
        drain_responses();
    endtask

    // Zero deadline, saturation both ways, release exactly at the deadline,
    // and equal saturated deadlines leaving in schedule order
    task automatic test_deadline_edges();
        send_request(make_schedule(32'd0, 32'd0, 8'h00));
        send_request(make_schedule(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
        send_request(make_schedule(32'hFFFF_FFF0, 32'h0000_0010, 8'h5A));
        send_request(make_schedule(32'd10, 32'd5, 8'hA5));
        send_request(make_update(32'd14));
        send_request(make_update(32'd15));
        send_request(make_update(32'hFFFF_FFFE));
        send_request(make_update(32'hFFFF_FFFF));
        drain_responses();
    endtask

    // Fill with tied deadlines, overflow by one, then release the whole queue
    task automatic test_full_queue();
        int k;
        for (k = 0; k < QUEUE_DEPTH; k++)
            send_request(make_schedule(32'd1000, 32'((k % 4) * 10), 8'(8'h30 + k)));
        send_request(make_schedule(32'd1000, 32'd0, 8'hEE));
        send_request(make_update(32'hFFFF_FFFF));
        drain_responses();
    endtask

    // Hold the receiver off while requests keep coming, so the block backs up
    task automatic test_output_backpressure();
        int k;
        rx_hold_req = 300;
        @(posedge i_clk);
        for (k = 0; k < 6; k++)
            send_request(make_schedule(32'd5000, 32'(k), 8'(8'hC0 + k)));
        send_request(make_update(32'd5010));
        send_request(make_update(32'd5011));
        drain_responses();
    endtask

    // Mostly well-formed traffic around a running tick, with fill bursts and noise
    task automatic test_random_traffic(input int n_items);
        int               k;
        int               sel;
        int               fill_left;
        logic [31:0]      delay;
        dtq_pkg::t_in_req req;
        fill_left = 0;
        sim_tick  = 32'd100;
        for (k = 0; k < n_items; k++) begin
            // Now and then jump near the top of the time range
            if ($urandom_range(0, 99) == 0)
                sim_tick = 32'hFFFF_FF00 + $urandom_range(0, 200);
            if (fill_left == 0 && $urandom_range(0, 59) == 0)
                fill_left = QUEUE_DEPTH + 2;
            sel = $urandom_range(0, 99);
            if (fill_left == 0 && sel < 12) begin
                req             = '0;
                req.command     = 1'($urandom);
                req.now_time    = $urandom;
                req.delay_ticks = $urandom;
                req.token       = 8'($urandom);
            end else if (fill_left > 0 || sel < 62) begin
                sel = $urandom_range(0, 99);
                if (sel < 70)
                    delay = $urandom_range(0, 64);
                else if (sel < 85)
                    delay = $urandom_range(0, 4096);
                else if (sel < 95)
                    delay = $urandom;
                else
                    delay = 32'hFFFF_FFFF - $urandom_range(0, 3);
                req = make_schedule(sim_tick, delay, 8'($urandom));
                if (fill_left > 0)
                    fill_left--;
            end else begin
                sim_tick = sim_tick + $urandom_range(0, 40);
                req = make_update(sim_tick);
            end
            send_request(req);
        end
        // Flush whatever is still stored
        send_request(make_update(32'hFFFF_FFFF));
        drain_responses();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_update();
        test_deadline_edges();
        test_full_queue();
        test_output_backpressure();
        test_random_traffic(330);

        // Let any stray response show up before closing
        repeat (40) @(posedge i_clk);

        $display("Run covered %0d requests: %0d tokens stored, %0d dropped on a full queue.",
                 n_requests, n_scheduled, n_dropped);
        $display("Updates released %0d tokens; %0d updates found nothing due.",
                 n_released, n_idle_upd);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
